// ===== rtl/masked_depth_minmax_normalize_assert.svh =====
// assertion macros shared by the masked depth normalize block
`ifndef MASKED_DEPTH_MINMAX_NORMALIZE_ASSERT_SVH
`define MASKED_DEPTH_MINMAX_NORMALIZE_ASSERT_SVH

`ifndef SYNTHESIS
`define MDMN_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("mdmn assertion failed");
`define MDMN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
	else $error("mdmn assertion failed");
`else
`define MDMN_ASSERT(lbl, clk, rst_n, prop)
`define MDMN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/mdmn_pkg.sv =====
// shared constants and types of the masked depth normalize block
package mdmn_pkg;

	localparam int DEPTH_BITS_DEF = 24;
	localparam int FIFO_DEPTH_DEF = 4;

	// quotient of the divider is one byte
	localparam int QBITS = 8;
	localparam int CNT_W = 3;
	localparam logic [QBITS-1:0] BYTE_MAX = 8'd255;
	localparam logic [QBITS-1:0] BYTE_ZERO = 8'd0;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} bk_state_t;

endpackage

// ===== rtl/mdmn_fifo.sv =====
// small request queue between the front and back parts
`include "masked_depth_minmax_normalize_assert.svh"

module mdmn_fifo import mdmn_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_q;
	logic [AW:0]      rd_q;

	assign empty = (wr_q == rd_q);
	assign full  = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
	assign rdata = mem_q[rd_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q[AW-1:0]] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	`MDMN_ASSERT(a_no_overflow, clk, arst_n, !(push && full))
	`MDMN_ASSERT(a_no_underflow, clk, arst_n, !(pop && empty))

endmodule

// ===== rtl/mdmn_front.sv =====
// front part: scan-pass min/max tracking and normalize-pass classification
module mdmn_front import mdmn_pkg::*; #(
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic                  command,
	input  logic [DEPTH_BITS-1:0] depth_value,
	input  logic                  mask_on,
	input  logic                  last_pixel,
	input  logic                  q_full,
	output logic                  q_push,
	output logic                  ent_direct,
	output logic [QBITS-1:0]      ent_byte,
	output logic [DEPTH_BITS-1:0] ent_diff,
	output logic [DEPTH_BITS-1:0] ent_range,
	output logic                  ent_last
);

	logic [DEPTH_BITS-1:0] run_min_q, run_max_q, held_min_q, held_range_q;
	logic                  run_found_q, held_valid_q;

	logic                  acc, upd;
	logic [DEPTH_BITS-1:0] nmin, nmax;
	logic                  nfound, frame_ok;
	logic [DEPTH_BITS:0]   diff_w;
	logic                  le_min, ge_range, pass;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;

	// scan pass: a pixel counts when masked and depth above zero
	assign upd      = mask_on && (depth_value != '0);
	assign nmin     = (upd && (depth_value < run_min_q)) ? depth_value : run_min_q;
	assign nmax     = (upd && (depth_value > run_max_q)) ? depth_value : run_max_q;
	assign nfound   = run_found_q || upd;
	assign frame_ok = nfound && (nmax > nmin);

	// normalize pass: sort out the cases that need no division
	assign diff_w   = {1'b0, depth_value} - {1'b0, held_min_q};
	assign le_min   = diff_w[DEPTH_BITS] || (diff_w[DEPTH_BITS-1:0] == '0);
	assign ge_range = (diff_w[DEPTH_BITS-1:0] >= held_range_q);
	assign pass     = mask_on && held_valid_q;

	assign q_push     = acc && command;
	assign ent_direct = !pass || le_min || ge_range;
	assign ent_byte   = (pass && le_min) ? BYTE_MAX : BYTE_ZERO;
	assign ent_diff   = diff_w[DEPTH_BITS-1:0];
	assign ent_range  = held_range_q;
	assign ent_last   = last_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q    <= '1;
			run_max_q    <= '0;
			run_found_q  <= 1'b0;
			held_min_q   <= '0;
			held_range_q <= '0;
			held_valid_q <= 1'b0;
		end else if (acc && !command) begin
			if (last_pixel) begin
				held_valid_q <= frame_ok;
				held_min_q   <= frame_ok ? nmin : '0;
				held_range_q <= frame_ok ? (nmax - nmin) : '0;
				run_min_q    <= '1;
				run_max_q    <= '0;
				run_found_q  <= 1'b0;
			end else begin
				run_min_q   <= nmin;
				run_max_q   <= nmax;
				run_found_q <= nfound;
			end
		end
	end

endmodule

// ===== rtl/mdmn_back.sv =====
// back part: restoring divider, byte inversion and output register
`include "masked_depth_minmax_normalize_assert.svh"

module mdmn_back import mdmn_pkg::*; #(
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	output logic                  q_pop,
	input  logic                  ent_direct,
	input  logic [QBITS-1:0]      ent_byte,
	input  logic [DEPTH_BITS-1:0] ent_diff,
	input  logic [DEPTH_BITS-1:0] ent_range,
	input  logic                  ent_last,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [QBITS-1:0]      depth_byte,
	output logic                  frame_end
);

	localparam int NW = DEPTH_BITS + QBITS;

	bk_state_t             state_q, state_d;
	logic [NW-1:0]         rem_q, dv_q;
	logic [DEPTH_BITS-1:0] range_q;
	logic [QBITS-1:0]      quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  last_q;
	logic                  out_valid_q, out_last_q;
	logic [QBITS-1:0]      out_byte_q;

	logic                  free, load_out, start_div, out_last_d, ge;
	logic [QBITS-1:0]      out_byte_d;
	logic [QBITS:0]        ceil_q;

	assign free   = !out_valid_q || m_tready;
	assign ge     = (rem_q >= dv_q);
	// ceiling: round up when the division left a remainder
	assign ceil_q = {1'b0, quo_q} + {{QBITS{1'b0}}, (rem_q != '0)};

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		load_out   = 1'b0;
		start_div  = 1'b0;
		out_byte_d = ent_byte;
		out_last_d = ent_last;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty && free) begin
					q_pop = 1'b1;
					if (ent_direct) begin
						load_out = 1'b1;
					end else begin
						start_div = 1'b1;
						state_d   = BK_DIV;
					end
				end
			end
			BK_DIV: begin
				if (cnt_q == '0) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				out_byte_d = BYTE_MAX - ceil_q[QBITS-1:0];
				out_last_d = last_q;
				if (free) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// divider datapath: numerator diff*255, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start_div) begin
			rem_q   <= {ent_diff, {QBITS{1'b0}}} - {{QBITS{1'b0}}, ent_diff};
			dv_q    <= {1'b0, ent_range, {(QBITS-1){1'b0}}};
			range_q <= ent_range;
			quo_q   <= '0;
			cnt_q   <= CNT_W'(QBITS - 1);
			last_q  <= ent_last;
		end else if (state_q == BK_DIV) begin
			if (ge) begin
				rem_q <= rem_q - dv_q;
			end
			quo_q <= {quo_q[QBITS-2:0], ge};
			dv_q  <= dv_q >> 1;
			cnt_q <= cnt_q - 1'b1;
		end
		if (load_out) begin
			out_byte_q <= out_byte_d;
			out_last_q <= out_last_d;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign depth_byte = out_byte_q;
	assign frame_end  = out_last_q;

	`MDMN_ASSERT(a_rem_below_range, clk, arst_n,
		(state_q == BK_DONE) |-> (rem_q < {{QBITS{1'b0}}, range_q}))
	`MDMN_ASSERT(a_ceil_fits, clk, arst_n,
		(state_q == BK_DONE) |-> !ceil_q[QBITS])
	`MDMN_ASSERT_NEXT(a_div_to_done, clk, arst_n,
		(state_q == BK_DIV) && (cnt_q == '0), state_q == BK_DONE)

endmodule

// ===== rtl/masked_depth_minmax_normalize.sv =====
// top level of the masked depth min/max normalize block
//
// channel | dir | tdata (low bit up)               | tuser   | tlast
// s_*     | in  | depth_value, mask_on, zero pad   | command | last_pixel
// m_*     | out | depth_byte                       | -       | frame_end
//
// scan-pass requests never produce a result
// normalize requests that need no division leave at one per cycle while the sink takes them
// a request that needs the divide goes through these steps in the back part:
// one pop, eight restoring steps of the shared divider, one result load
// a four-entry queue lets the front keep scanning while the divider works
// reset restores all trackers and clears the held min/range; no clearing pass
module masked_depth_minmax_normalize import mdmn_pkg::*; #(
	parameter int DEPTH_BITS = DEPTH_BITS_DEF,
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// depth_value [DEPTH_BITS-1:0], mask_on, zero pad to whole bytes
	input  logic [((DEPTH_BITS+8)/8)*8-1:0] s_tdata,
	// command
	input  logic         s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// depth_byte
	output logic [QBITS-1:0] m_tdata,
	output logic         m_tlast
);

	// queue entry: diff, range, byte, direct flag, last flag
	localparam int EW = 2 * DEPTH_BITS + QBITS + 2;

	logic                  q_full, q_empty, q_push, q_pop;
	logic [EW-1:0]         q_wdata, q_rdata;

	logic                  f_direct, f_last;
	logic [QBITS-1:0]      f_byte;
	logic [DEPTH_BITS-1:0] f_diff, f_range;

	logic                  b_direct, b_last;
	logic [QBITS-1:0]      b_byte;
	logic [DEPTH_BITS-1:0] b_diff, b_range;

	// front: tracks min/max in the scan pass, classifies normalize requests
	mdmn_front #(
		.DEPTH_BITS(DEPTH_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.command    (s_tuser),
		.depth_value(s_tdata[DEPTH_BITS-1:0]),
		.mask_on    (s_tdata[DEPTH_BITS]),
		.last_pixel (s_tlast),
		.q_full     (q_full),
		.q_push     (q_push),
		.ent_direct (f_direct),
		.ent_byte   (f_byte),
		.ent_diff   (f_diff),
		.ent_range  (f_range),
		.ent_last   (f_last)
	);

	assign q_wdata = {f_last, f_direct, f_byte, f_range, f_diff};

	// queue decouples the front from the divider
	mdmn_fifo #(
		.WIDTH(EW),
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign b_diff   = q_rdata[DEPTH_BITS-1:0];
	assign b_range  = q_rdata[2*DEPTH_BITS-1:DEPTH_BITS];
	assign b_byte   = q_rdata[2*DEPTH_BITS+QBITS-1:2*DEPTH_BITS];
	assign b_direct = q_rdata[2*DEPTH_BITS+QBITS];
	assign b_last   = q_rdata[2*DEPTH_BITS+QBITS+1];

	// back: divides when needed and holds the result for the sink
	mdmn_back #(
		.DEPTH_BITS(DEPTH_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.ent_direct(b_direct),
		.ent_byte  (b_byte),
		.ent_diff  (b_diff),
		.ent_range (b_range),
		.ent_last  (b_last),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.depth_byte(m_tdata),
		.frame_end (m_tlast)
	);

endmodule
